// ===== rtl/qpht_pkg.sv =====
// Package for the quadratic-probe hash table: widths, operation, status and
// register codes, and the slot/hash/load helpers. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

    // Table geometry
    localparam int MAX_SLOTS_LOG2 = 10;
    localparam int WORD_W         = 32;
    localparam int SLOT_W         = MAX_SLOTS_LOG2;
    localparam int SLOT_DEPTH     = 1 << SLOT_W;
    localparam int CNT_W          = SLOT_W + 1;
    localparam int LG_W           = $clog2(MAX_SLOTS_LOG2 + 1);
    localparam int GROW_W         = CNT_W + 3;
    localparam int PROBE_STEP0    = 8;

    // Field widths
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int LOG2_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] HASH_MASK = WORD_W'(32'h7FFF_FFF8);

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [LG_W-1:0]     lg_t;
    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Operation codes
    localparam op_t OP_INSERT   = 3'd0;
    localparam op_t OP_LOOKUP   = 3'd1;
    localparam op_t OP_REMOVE   = 3'd2;
    localparam op_t OP_QUERY_EN = 3'd3;
    localparam op_t OP_SET_EN   = 3'd4;

    // Status codes
    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_FOUND     = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_INVALID   = 3'd4;
    localparam status_t ST_DONE      = 3'd5;

    // Register indexes
    localparam cfg_idx_t CFG_SLOT_LOG2   = 2'd0;
    localparam cfg_idx_t CFG_FLAG_EN     = 2'd1;
    localparam cfg_idx_t CFG_DEL_MARKER  = 2'd2;
    localparam cfg_idx_t CFG_ABSENT_VAL  = 2'd3;

    // Clamp the programmed slot log2 into the supported range
    function automatic lg_t eff_log2(logic [LOG2_W-1:0] cfg);
        lg_t r;
        if (cfg == '0)
            r = LG_W'(1);
        else if (int'(cfg) > MAX_SLOTS_LOG2)
            r = LG_W'(MAX_SLOTS_LOG2);
        else
            r = LG_W'(cfg);
        return r;
    endfunction

    function automatic slot_t slot_mask(lg_t lg);
        return SLOT_W'((32'd1 << lg) - 32'd1);
    endfunction

    function automatic slot_t home_slot(word_t mk, slot_t mask);
        word_t h;
        h = (mk & HASH_MASK) >> 3;
        return h[SLOT_W-1:0] & mask;
    endfunction

    // Load rule: 5*(count+1) >= 4*slots
    function automatic logic load_rule(cnt_t cnt, lg_t lg);
        logic [GROW_W-1:0] lhs;
        logic [GROW_W-1:0] rhs;
        lhs = (GROW_W'(cnt) + GROW_W'(1)) * GROW_W'(5);
        rhs = GROW_W'(4) << lg;
        return lhs >= rhs;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qpht_if.sv =====
// Item channels of the quadratic-probe hash table: request and result.
// Depends on qpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface qpht_in_if;
    import qpht_pkg::*;
    logic  valid;
    logic  ready;
    op_t   operation;
    word_t key;
    word_t item_value;
    logic  enumerable;

    modport source (output valid, operation, key, item_value, enumerable, input ready);
    modport sink   (input valid, operation, key, item_value, enumerable, output ready);
endinterface

interface qpht_out_if;
    import qpht_pkg::*;
    logic    valid;
    logic    ready;
    status_t status;
    word_t   result_value;
    logic    is_enumerable;
    logic    needs_grow;
    cnt_t    entry_total;
    logic    holds_deleted;

    modport source (output valid, status, result_value, is_enumerable, needs_grow,
                    entry_total, holds_deleted, input ready);
    modport sink   (input valid, status, result_value, is_enumerable, needs_grow,
                    entry_total, holds_deleted, output ready);
endinterface

`default_nettype wire

// ===== rtl/quadratic_probe_hash_table.sv =====
// Top level of the quadratic-probe hash table: key and value memories,
// probe sequencer and result register. Depends on qpht_pkg and qpht_if.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  req     | in  | valid/ready   | operation, key, item_value, enumerable
//  rsp     | out | valid/ready   | status, result_value, is_enumerable,
//          |     |               | needs_grow, entry_total, holds_deleted
//  cfg     | in  | cfg_write     | cfg_index, cfg_data
//
// An item is accepted, then probes P slots (0 for invalid keys and unknown
// operations, which skip the probe) with one key-memory read per probe, and
// then writes back and posts the result.
// After reset and after each write of slot_log2 a clearing pass empties all
// 1024 key-memory slots, during which no item is taken.
// A result waiting in the output register does not block the next item; only
// the write-back cycle waits for that register to drain.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_probe_hash_table (
    input  wire                        clk,
    input  wire                        rst_n,
    qpht_in_if.sink                    req,
    qpht_out_if.source                 rsp,
    input  wire                        cfg_write,
    input  wire qpht_pkg::cfg_idx_t    cfg_index,
    input  wire qpht_pkg::word_t       cfg_data
);
    import qpht_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_ACT   = 2'd3;

    // Memories
    word_t key_mem [SLOT_DEPTH];
    word_t val_mem [SLOT_DEPTH];

    // Configuration
    logic [LOG2_W-1:0] slot_log2_reg;
    logic              flag_en_reg;
    word_t             marker_reg;
    word_t             absent_reg;

    // Control and table status
    logic [1:0] state_reg, state_next;
    slot_t      clr_addr_reg, clr_addr_next;
    cnt_t       count_reg, count_next;
    logic       deleted_reg, deleted_next;

    // Item in flight
    op_t        op_reg, op_next;
    word_t      mk_reg, mk_next;
    word_t      val_in_reg, val_in_next;
    logic       en_reg, en_next;
    slot_t      idx_reg, idx_next;
    slot_t      step_reg, step_next;
    slot_t      probe_reg, probe_next;
    logic       skip_reg, skip_next;
    status_t    skip_status_reg, skip_status_next;
    logic       found_reg, found_next;
    word_t      kdat_reg, kdat_next;
    word_t      vdat_reg, vdat_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    status_t    out_status_reg, out_status_next;
    word_t      out_value_reg, out_value_next;
    logic       out_isen_reg, out_isen_next;
    logic       out_grow_reg, out_grow_next;
    cnt_t       out_total_reg, out_total_next;
    logic       out_del_reg, out_del_next;

    // Memory ports
    slot_t      rd_addr;
    word_t      key_rd, val_rd;
    logic       key_we, val_we;
    slot_t      wr_addr;
    word_t      key_wdata, val_wdata;

    // Derived configuration
    lg_t        lg_eff;
    slot_t      mask;
    word_t      fmask;
    word_t      mk_in;
    word_t      kd_masked;
    logic       hit;
    logic       stop;
    logic       out_free;

    assign lg_eff   = eff_log2(slot_log2_reg);
    assign mask     = slot_mask(lg_eff);
    assign fmask    = flag_en_reg ? ~WORD_W'(1) : '1;
    assign mk_in    = req.key & fmask;
    assign kd_masked = key_rd & fmask;
    assign hit      = (kd_masked == mk_reg);
    assign stop     = hit || (kd_masked == '0);
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.result_value  = out_value_reg;
    assign rsp.is_enumerable = out_isen_reg;
    assign rsp.needs_grow    = out_grow_reg;
    assign rsp.entry_total   = out_total_reg;
    assign rsp.holds_deleted = out_del_reg;

    // Key and value memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_wdata;
        end
        key_rd <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[wr_addr] <= val_wdata;
        end
        val_rd <= val_mem[rd_addr];
    end

    // Sequencer: accept, probe one slot a cycle, then modify and post the result
    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        count_next       = count_reg;
        deleted_next     = deleted_reg;
        op_next          = op_reg;
        mk_next          = mk_reg;
        val_in_next      = val_in_reg;
        en_next          = en_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        probe_next       = probe_reg;
        skip_next        = skip_reg;
        skip_status_next = skip_status_reg;
        found_next       = found_reg;
        kdat_next        = kdat_reg;
        vdat_next        = vdat_reg;

        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_value_next   = out_value_reg;
        out_isen_next    = out_isen_reg;
        out_grow_next    = out_grow_reg;
        out_total_next   = out_total_reg;
        out_del_next     = out_del_reg;

        rd_addr   = idx_reg;
        key_we    = 1'b0;
        val_we    = 1'b0;
        wr_addr   = idx_reg;
        key_wdata = mk_reg;
        val_wdata = val_in_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Empty one key slot a cycle
                key_we        = 1'b1;
                wr_addr       = clr_addr_reg;
                key_wdata     = '0;
                clr_addr_next = clr_addr_reg + SLOT_W'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                rd_addr = home_slot(mk_in, mask);
                if (req.valid)
                begin
                    op_next     = req.operation;
                    mk_next     = mk_in;
                    val_in_next = req.item_value;
                    en_next     = req.enumerable;
                    idx_next    = home_slot(mk_in, mask);
                    step_next   = SLOT_W'(PROBE_STEP0);
                    probe_next  = '0;
                    skip_next   = 1'b1;
                    priority if (req.operation > OP_SET_EN)
                    begin
                        skip_status_next = ST_DONE;
                        state_next       = S_ACT;
                    end
                    else if (mk_in == '0 || mk_in == (marker_reg & fmask))
                    begin
                        skip_status_next = ST_INVALID;
                        state_next       = S_ACT;
                    end
                    else
                    begin
                        skip_next  = 1'b0;
                        state_next = S_PROBE;
                    end
                end
            end

            S_PROBE:
            begin
                if (stop)
                begin
                    found_next = hit;
                    kdat_next  = key_rd;
                    vdat_next  = val_rd;
                    state_next = S_ACT;
                end
                else if (probe_reg == mask)
                begin
                    // As many probes as slots made without a stop
                    skip_next        = 1'b1;
                    skip_status_next = ST_FULL;
                    state_next       = S_ACT;
                end
                else
                begin
                    idx_next   = (idx_reg + step_reg) & mask;
                    step_next  = step_reg + SLOT_W'(1);
                    probe_next = probe_reg + SLOT_W'(1);
                    rd_addr    = (idx_reg + step_reg) & mask;
                end
            end

            S_ACT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = absent_reg;
                    out_isen_next   = 1'b0;
                    out_status_next = ST_DONE;
                    if (skip_reg)
                    begin
                        out_status_next = skip_status_reg;
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_INSERT:
                            begin
                                priority if (found_reg)
                                begin
                                    val_we          = 1'b1;
                                    out_status_next = ST_FOUND;
                                end
                                else if (load_rule(count_reg, lg_eff))
                                begin
                                    out_status_next = ST_FULL;
                                end
                                else
                                begin
                                    key_we          = 1'b1;
                                    val_we          = 1'b1;
                                    count_next      = count_reg + CNT_W'(1);
                                    out_status_next = ST_INSERTED;
                                end
                            end
                            OP_LOOKUP:
                            begin
                                if (found_reg)
                                begin
                                    out_status_next = ST_FOUND;
                                    out_value_next  = vdat_reg;
                                end
                                else
                                begin
                                    out_status_next = ST_NOT_FOUND;
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (found_reg)
                                begin
                                    out_status_next = ST_FOUND;
                                    out_value_next  = vdat_reg;
                                    key_we          = 1'b1;
                                    val_we          = 1'b1;
                                    key_wdata       = marker_reg;
                                    val_wdata       = marker_reg;
                                    deleted_next    = 1'b1;
                                end
                                else
                                begin
                                    out_status_next = ST_NOT_FOUND;
                                end
                            end
                            OP_QUERY_EN:
                            begin
                                if (found_reg)
                                begin
                                    out_status_next = ST_FOUND;
                                    out_isen_next   = flag_en_reg ? !kdat_reg[0] : 1'b1;
                                end
                                else
                                begin
                                    out_status_next = ST_NOT_FOUND;
                                end
                            end
                            OP_SET_EN:
                            begin
                                priority if (!flag_en_reg)
                                begin
                                    out_status_next = ST_DONE;
                                end
                                else if (!found_reg)
                                begin
                                    out_status_next = ST_NOT_FOUND;
                                end
                                else
                                begin
                                    key_we          = 1'b1;
                                    key_wdata       = {kdat_reg[WORD_W-1:1], !en_reg};
                                    out_status_next = ST_DONE;
                                end
                            end
                            default:
                            begin
                                out_status_next = ST_DONE;
                            end
                        endcase
                    end
                    out_grow_next  = load_rule(count_next, lg_eff);
                    out_total_next = count_next;
                    out_del_next   = deleted_next;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // Resizing restarts the clearing pass and drops the counts
        if (cfg_write && cfg_index == CFG_SLOT_LOG2)
        begin
            state_next    = S_CLEAR;
            clr_addr_next = '0;
            count_next    = '0;
            deleted_next  = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            deleted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_log2_reg <= LOG2_W'(3);
            flag_en_reg   <= 1'b0;
            marker_reg    <= WORD_W'(4);
            absent_reg    <= WORD_W'(4);
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            deleted_reg   <= deleted_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SLOT_LOG2:  slot_log2_reg <= cfg_data[LOG2_W-1:0];
                    CFG_FLAG_EN:    flag_en_reg   <= cfg_data[0];
                    CFG_DEL_MARKER: marker_reg    <= cfg_data;
                    CFG_ABSENT_VAL: absent_reg    <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        mk_reg          <= mk_next;
        val_in_reg      <= val_in_next;
        en_reg          <= en_next;
        idx_reg         <= idx_next;
        step_reg        <= step_next;
        probe_reg       <= probe_next;
        skip_reg        <= skip_next;
        skip_status_reg <= skip_status_next;
        found_reg       <= found_next;
        kdat_reg        <= kdat_next;
        vdat_reg        <= vdat_next;
        out_status_reg  <= out_status_next;
        out_value_reg   <= out_value_next;
        out_isen_reg    <= out_isen_next;
        out_grow_reg    <= out_grow_next;
        out_total_reg   <= out_total_next;
        out_del_reg     <= out_del_next;
    end

endmodule

`default_nettype wire
